>>> rtl/pgtb_pkg.sv
// Package for the paired glyph planar text blitter.
// It holds the item structs, opcodes, register indexes and font constants.
// No dependencies; every other file imports it.
`default_nettype none
package pgtb_pkg;

  // Font geometry and cell stepping.
  localparam int GLYPH_ROWS   = 8;
  localparam int CELL_STEP    = 8;
  localparam int FONT_AW      = 11;
  localparam int FONT_DEPTH   = 2048;
  localparam logic [2:0] LAST_ROW    = 3'(GLYPH_ROWS - 1);
  localparam logic [7:0] SUBST_GLYPH = 8'h2f;
  localparam logic [15:0] STRIDE_RESET = 16'd160;

  // Input opcodes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FILL_LO = 2'd0;
  localparam logic [1:0] CFG_FILL_HI = 2'd1;
  localparam logic [1:0] CFG_STRIDE  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  glyph_index;
    logic [2:0]  glyph_row;
    logic [15:0] glyph_word;
    logic [23:0] start_address;
    logic [15:0] cell_budget_m1;
    logic [7:0]  text_byte;
  } in_item_t;

  typedef struct packed {
    logic [23:0] write_address;
    logic [31:0] and_mask;
    logic [31:0] or_plane_lo;
    logic [31:0] or_plane_hi;
    logic        write_valid;
    logic        string_ended;
    logic        last;
  } out_item_t;

  // One row request from the sequencer to the output pipeline.
  typedef struct packed {
    logic        issue;
    logic [23:0] addr;
    logic        fin;
    logic        ended;
    logic        note;
  } row_req_t;

endpackage
`default_nettype wire

>>> rtl/paired_glyph_planar_text_blitter.sv
// Top level of the paired glyph planar text blitter: configuration registers,
// string sequencer, font memory and output pipeline. Uses pgtb_pkg, pgtb_font_ram
// and pgtb_row_pipe.
//
//   channel | ports                       | moves
//   --------+-----------------------------+---------------------------------
//   input   | in_valid, in_ready, in_item | font loads, starts, string bytes
//   output  | out_valid, out_ready,       | row writes and end notices
//           | out_item                    |
//   config  | cfg_we, cfg_index, cfg_data | fill planes and row stride
//
// A font load, a start or a first byte is taken while the sequencer is idle. The
// second byte of a pair issues GLYPH_ROWS font reads, one row per cycle through the
// two read ports of the font memory, and holds the input until its last row is issued;
// an end notice holds it until its request is issued. Results pass the wait stage,
// then the output register. A stall on the output holds the pipeline and the row reads.
// Reset is synchronous; the font memory is not cleared and has no meaning until loaded.
`default_nettype none
module paired_glyph_planar_text_blitter
  import pgtb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DRAW = 3'b010,
    ST_NOTE = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [23:0] cell_addr_r, cell_addr_nxt;
  logic [15:0] cells_rem_r, cells_rem_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        await_r, await_nxt;
  logic        active_r, active_nxt;
  logic [2:0]  row_r, row_nxt;
  logic [23:0] row_addr_r, row_addr_nxt;
  logic [7:0]  c1_r, c1_nxt;
  logic [7:0]  c2_r, c2_nxt;
  logic        ended_r, ended_nxt;
  logic [31:0] fill_lo_r;
  logic [31:0] fill_hi_r;
  logic [15:0] stride_r;

  logic        issue_ok;
  logic        issue;
  logic        font_we;
  logic [15:0] rem_base;
  logic [15:0] glyph_a;
  logic [15:0] glyph_b;
  row_req_t    req;

  assign in_ready = (state_r == ST_IDLE);
  assign issue    = issue_ok && ((state_r == ST_DRAW) || (state_r == ST_NOTE));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_lo_r <= '0;
      fill_hi_r <= '0;
      stride_r  <= STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILL_LO: fill_lo_r <= cfg_data;
        CFG_FILL_HI: fill_hi_r <= cfg_data;
        CFG_STRIDE:  stride_r  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // String sequencer.
  always_comb begin
    state_nxt     = state_r;
    cell_addr_nxt = cell_addr_r;
    cells_rem_nxt = cells_rem_r;
    held_nxt      = held_r;
    await_nxt     = await_r;
    active_nxt    = active_r;
    row_nxt       = row_r;
    row_addr_nxt  = row_addr_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    ended_nxt     = ended_r;
    font_we       = 1'b0;
    rem_base      = (in_item.text_byte == 8'd0) ? 16'd0 : cells_rem_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_item.opcode)
            OP_LOAD: font_we = 1'b1;
            OP_START: begin
              cell_addr_nxt = in_item.start_address;
              cells_rem_nxt = in_item.cell_budget_m1;
              held_nxt      = '0;
              await_nxt     = 1'b0;
              active_nxt    = 1'b1;
            end
            OP_BYTE: begin
              if (active_r) begin
                if (!await_r) begin
                  if (in_item.text_byte == 8'd0) begin
                    active_nxt = 1'b0;
                    state_nxt  = ST_NOTE;
                  end else begin
                    held_nxt  = in_item.text_byte;
                    await_nxt = 1'b1;
                  end
                end else begin
                  // Second byte of a pair: set up the cell draw.
                  await_nxt     = 1'b0;
                  c1_nxt        = held_r;
                  c2_nxt        = (in_item.text_byte == 8'd0) ? SUBST_GLYPH
                                                              : in_item.text_byte;
                  cells_rem_nxt = rem_base - 16'd1;
                  ended_nxt     = (cells_rem_nxt == 16'hffff);
                  row_nxt       = '0;
                  row_addr_nxt  = cell_addr_r;
                  state_nxt     = ST_DRAW;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAW: begin
        if (issue) begin
          if (row_r == LAST_ROW) begin
            state_nxt     = ST_IDLE;
            cell_addr_nxt = cell_addr_r + 24'(CELL_STEP);
            if (ended_r) begin
              active_nxt = 1'b0;
            end
          end else begin
            row_nxt      = row_r + 3'd1;
            row_addr_nxt = row_addr_r + {8'd0, stride_r};
          end
        end
      end
      ST_NOTE: begin
        if (issue) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cell_addr_r <= '0;
      cells_rem_r <= '0;
      held_r      <= '0;
      await_r     <= 1'b0;
      active_r    <= 1'b0;
      row_r       <= '0;
      ended_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cell_addr_r <= cell_addr_nxt;
      cells_rem_r <= cells_rem_nxt;
      held_r      <= held_nxt;
      await_r     <= await_nxt;
      active_r    <= active_nxt;
      row_r       <= row_nxt;
      ended_r     <= ended_nxt;
    end
  end

  // Cell draw payload registers.
  always_ff @(posedge clk) begin
    row_addr_r <= row_addr_nxt;
    c1_r       <= c1_nxt;
    c2_r       <= c2_nxt;
  end

  // Row request toward the output pipeline.
  always_comb begin
    req.issue = issue;
    req.addr  = row_addr_r;
    req.fin   = (row_r == LAST_ROW);
    req.ended = ended_r && (row_r == LAST_ROW);
    req.note  = (state_r == ST_NOTE);
  end

  pgtb_font_ram u_font (
    .clk     (clk),
    .we      (font_we),
    .waddr   ({in_item.glyph_index, in_item.glyph_row}),
    .wdata   (in_item.glyph_word),
    .re      (issue),
    .raddr_a ({c1_r, row_r}),
    .raddr_b ({c2_r, row_r}),
    .rdata_a (glyph_a),
    .rdata_b (glyph_b)
  );

  pgtb_row_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .issue_ok  (issue_ok),
    .glyph_a   (glyph_a),
    .glyph_b   (glyph_b),
    .fill_lo   (fill_lo_r),
    .fill_hi   (fill_hi_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> rtl/pgtb_font_ram.sv
// Font memory: 2048 words of 16 bits, one write port and two read ports.
// Read data is registered and holds while the read enable is low. Uses pgtb_pkg.
`default_nettype none
module pgtb_font_ram
  import pgtb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [FONT_AW-1:0] waddr,
  input  wire logic [15:0]        wdata,
  input  wire logic               re,
  input  wire logic [FONT_AW-1:0] raddr_a,
  input  wire logic [FONT_AW-1:0] raddr_b,
  output logic      [15:0]        rdata_a,
  output logic      [15:0]        rdata_b
);

  logic [15:0] mem [FONT_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports sharing one enable.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

>>> rtl/pgtb_row_pipe.sv
// Output pipeline: a stage that waits on the font read data, then the output
// register that formats one row write or end notice. Uses pgtb_pkg.
`default_nettype none
module pgtb_row_pipe
  import pgtb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire row_req_t    req,
  output logic             issue_ok,
  input  wire logic [15:0] glyph_a,
  input  wire logic [15:0] glyph_b,
  input  wire logic [31:0] fill_lo,
  input  wire logic [31:0] fill_hi,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item
);

  logic        s1_valid_r;
  logic [23:0] s1_addr_r;
  logic        s1_fin_r;
  logic        s1_ended_r;
  logic        s1_note_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        adv2;
  logic [31:0] mask_w;
  logic [31:0] ink_w;
  out_item_t   fmt;

  assign adv2     = !out_valid_r || out_ready;
  assign issue_ok = !s1_valid_r || adv2;

  // Combine the two glyph rows and duplicate into both halves.
  always_comb begin
    mask_w = {glyph_a[15:8], glyph_b[15:8], glyph_a[15:8], glyph_b[15:8]};
    ink_w  = {glyph_a[7:0], glyph_b[7:0], glyph_a[7:0], glyph_b[7:0]};
    if (s1_note_r) begin
      fmt = '0;
      fmt.string_ended = 1'b1;
      fmt.last         = 1'b1;
    end else begin
      fmt.write_address = s1_addr_r;
      fmt.and_mask      = mask_w;
      fmt.or_plane_lo   = ink_w & fill_lo;
      fmt.or_plane_hi   = ink_w & fill_hi;
      fmt.write_valid   = 1'b1;
      fmt.string_ended  = s1_ended_r;
      fmt.last          = s1_fin_r;
    end
  end

  // Valid flags of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue_ok) begin
        s1_valid_r <= req.issue;
      end
      if (adv2) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (issue_ok && req.issue) begin
      s1_addr_r  <= req.addr;
      s1_fin_r   <= req.fin;
      s1_ended_r <= req.ended;
      s1_note_r  <= req.note;
    end
    if (adv2 && s1_valid_r) begin
      out_item_r <= fmt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

>>> dv/paired_glyph_planar_text_blitter_tb.sv
// Self-checking testbench for the paired glyph planar text blitter.
// It drives font loads, string starts and string bytes, predicts every row write and
// end notice, and compares them field by field. Depends on pgtb_pkg and the RTL top.
`default_nettype none
module paired_glyph_planar_text_blitter_tb;
  import pgtb_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         DRAIN_CYCLES = 2 * GLYPH_ROWS + 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FILL_LO;
  logic [31:0] cfg_data = '0;

  always #1 clk = ~clk;

  paired_glyph_planar_text_blitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Items waiting for the driver and row writes waiting for the block.
  in_item_t  pending_items[$];
  out_item_t expected_rows[$];
  int        items_queued = 0;
  int        items_taken = 0;
  int        errors = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        quiet_cycles = 0;
  bit        idle_on = 1'b1;
  logic      in_taken = 1'b0;

  // Our own copy of the blitter state and its registers.
  logic [15:0] font_copy [FONT_DEPTH];
  logic [23:0] pen_addr = '0;
  logic [15:0] cells_left = '0;
  logic [7:0]  held_char = '0;
  logic        want_second = 1'b0;
  logic        text_on = 1'b0;
  logic [31:0] plane_lo_copy = '0;
  logic [31:0] plane_hi_copy = '0;
  logic [15:0] stride_copy = STRIDE_RESET;

  // Stimulus side view: which glyphs are fully loaded and where the string stands.
  bit [7:0]    rows_loaded [256];
  bit          is_drawable [256];
  logic [7:0]  drawable[$];
  bit          gen_on = 1'b0;
  bit          gen_second = 1'b0;
  logic [15:0] gen_left = '0;

  // Work out the row writes and end notices that one accepted item causes.
  task automatic predict_item(input in_item_t it);
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [15:0] g1;
    logic [15:0] g2;
    logic [15:0] ink16;
    logic        ended;
    out_item_t   row_out;
    int          row;
    case (it.opcode)
      OP_LOAD: font_copy[{it.glyph_index, it.glyph_row}] = it.glyph_word;
      OP_START: begin
        pen_addr    = it.start_address;
        cells_left  = it.cell_budget_m1;
        held_char   = '0;
        want_second = 1'b0;
        text_on     = 1'b1;
      end
      OP_BYTE: if (text_on) begin
        if (!want_second) begin
          // A zero first byte closes the string with a bare end notice.
          if (it.text_byte == 8'h00) begin
            row_out = '0;
            row_out.string_ended = 1'b1;
            row_out.last = 1'b1;
            expected_rows.push_back(row_out);
            text_on = 1'b0;
          end else begin
            held_char = it.text_byte;
            want_second = 1'b1;
          end
        end else begin
          want_second = 1'b0;
          c1 = held_char;
          c2 = it.text_byte;
          // A zero second byte draws the substitute glyph and makes this cell the last.
          if (c2 == 8'h00) begin
            c2 = SUBST_GLYPH;
            cells_left = '0;
          end
          cells_left = cells_left - 16'd1;
          ended = (cells_left == 16'hffff);
          for (row = 0; row < GLYPH_ROWS; row++) begin
            g1 = font_copy[{c1, 3'(row)}];
            g2 = font_copy[{c2, 3'(row)}];
            ink16 = {g1[7:0], g2[7:0]};
            row_out.write_address = pen_addr + 24'(row * stride_copy);
            row_out.and_mask      = {2{g1[15:8], g2[15:8]}};
            row_out.or_plane_lo   = {2{ink16}} & plane_lo_copy;
            row_out.or_plane_hi   = {2{ink16}} & plane_hi_copy;
            row_out.write_valid   = 1'b1;
            row_out.last          = (row == GLYPH_ROWS - 1);
            row_out.string_ended  = row_out.last && ended;
            expected_rows.push_back(row_out);
          end
          pen_addr = pen_addr + 24'(CELL_STEP);
          if (ended) text_on = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_row(input out_item_t want, input out_item_t got);
    check_field("write_address", 32'(want.write_address), 32'(got.write_address));
    check_field("and_mask", want.and_mask, got.and_mask);
    check_field("or_plane_lo", want.or_plane_lo, got.or_plane_lo);
    check_field("or_plane_hi", want.or_plane_hi, got.or_plane_hi);
    check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
    check_field("string_ended", 32'(want.string_ended), 32'(got.string_ended));
    check_field("last", 32'(want.last), 32'(got.last));
  endtask

  // Driver: new items and ready changes are applied at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_item <= pending_items.pop_front();
          if (idle_on && $urandom_range(0, 3) == 0) in_gap <= $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) out_gap <= $urandom_range(1, 3);
      end
    end
  end

  // Monitor: both handshakes are sampled at the rising edge; a long silence ends the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_item(in_item);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected result item at address %0h", out_item.write_address);
          errors++;
        end else begin
          check_row(expected_rows.pop_front(), out_item);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Queue one item and follow the string state it leads to.
  task automatic queue_item(input in_item_t it);
    case (it.opcode)
      OP_LOAD: begin
        rows_loaded[it.glyph_index][it.glyph_row] = 1'b1;
        if (rows_loaded[it.glyph_index] == 8'hff && it.glyph_index != 8'h00 &&
            !is_drawable[it.glyph_index]) begin
          is_drawable[it.glyph_index] = 1'b1;
          drawable.push_back(it.glyph_index);
        end
      end
      OP_START: begin
        gen_on = 1'b1;
        gen_second = 1'b0;
        gen_left = it.cell_budget_m1;
      end
      OP_BYTE: if (gen_on) begin
        if (!gen_second) begin
          if (it.text_byte == 8'h00) gen_on = 1'b0;
          else gen_second = 1'b1;
        end else begin
          gen_second = 1'b0;
          if (it.text_byte == 8'h00) gen_left = '0;
          gen_left = gen_left - 16'd1;
          if (gen_left == 16'hffff) gen_on = 1'b0;
        end
      end
      default: ;
    endcase
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Fields the opcode does not use carry random values.
  function automatic in_item_t noise_item(input logic [1:0] op);
    logic [95:0] raw;
    in_item_t    it;
    raw = {$urandom(), $urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    it.opcode = op;
    return it;
  endfunction

  task automatic send_load(input logic [7:0] glyph, input logic [2:0] row,
                           input logic [15:0] word);
    in_item_t it;
    it = noise_item(OP_LOAD);
    it.glyph_index = glyph;
    it.glyph_row = row;
    it.glyph_word = word;
    queue_item(it);
  endtask

  task automatic send_start(input logic [23:0] addr, input logic [15:0] budget);
    in_item_t it;
    it = noise_item(OP_START);
    it.start_address = addr;
    it.cell_budget_m1 = budget;
    queue_item(it);
  endtask

  task automatic send_byte(input logic [7:0] value);
    in_item_t it;
    it = noise_item(OP_BYTE);
    it.text_byte = value;
    queue_item(it);
  endtask

  task automatic load_glyph(input logic [7:0] glyph);
    logic [15:0] word;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      case ($urandom_range(0, 7))
        0: word = 16'h0000;
        1: word = 16'hffff;
        default: word = 16'($urandom());
      endcase
      send_load(glyph, 3'(r), word);
    end
  endtask

  function automatic logic [7:0] pick_glyph();
    return drawable[$urandom_range(0, drawable.size() - 1)];
  endfunction

  // Overwrite one row of a glyph that strings already draw.
  task automatic reload_row();
    send_load(pick_glyph(), 3'($urandom_range(0, GLYPH_ROWS - 1)), 16'($urandom()));
  endtask

  // One string: a start, a few pairs of loaded glyphs, and usually a terminator.
  task automatic draw_string();
    logic [23:0] addr;
    logic [15:0] budget;
    int          pairs;
    if ($urandom_range(0, 3) == 0) addr = {16'hffff, 8'($urandom())};
    else addr = 24'($urandom());
    case ($urandom_range(0, 9))
      0: budget = 16'hffff;
      1: budget = 16'h0000;
      2: budget = 16'($urandom());
      default: budget = 16'($urandom_range(0, 4));
    endcase
    send_start(addr, budget);
    pairs = $urandom_range(0, 6);
    for (int k = 0; k < pairs && gen_on; k++) begin
      if ($urandom_range(0, 9) == 0) reload_row();
      send_byte(pick_glyph());
      // Now and then a new start lands between the two bytes of a pair.
      if ($urandom_range(0, 19) == 0) send_start(24'($urandom()), 16'($urandom_range(0, 3)));
      send_byte(($urandom_range(0, 11) == 0) ? 8'h00 : pick_glyph());
    end
    if (gen_on && !gen_second && $urandom_range(0, 2) != 0) send_byte(8'h00);
  endtask

  task automatic random_phase(input int goal_items);
    int stop_at;
    stop_at = items_queued + goal_items;
    while (items_queued < stop_at) begin
      case ($urandom_range(0, 9))
        0: load_glyph(8'($urandom_range(0, 255)));
        1: begin
          // Noise: stray bytes while idle, unused opcodes, single row stores.
          if (!gen_on) send_byte(8'($urandom()));
          else queue_item(noise_item(OP_UNUSED));
          send_load(8'($urandom()), 3'($urandom()), 16'($urandom()));
        end
        default: draw_string();
      endcase
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FILL_LO: plane_lo_copy = value;
      CFG_FILL_HI: plane_hi_copy = value;
      CFG_STRIDE:  stride_copy = value[15:0];
      default: ;
    endcase
  endtask

  // Wait until every item is taken and every result has come, then let the block settle.
  task automatic settle();
    while (items_taken != items_queued || expected_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Stimulus sequence: directed cases first, then random phases under several settings.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_FILL_LO, 32'hffff_ffff);
    write_reg(CFG_FILL_HI, 32'h0000_0000);
    write_reg(CFG_STRIDE, 32'h0000_ffff);

    // Font for the directed part: the substitute glyph, a solid glyph and a blank one.
    load_glyph(SUBST_GLYPH);
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      send_load(8'hff, 3'(r), 16'hffff);
      send_load(8'h01, 3'(r), 16'h0000);
    end

    // Bytes with no string running and the unused opcode are ignored.
    send_byte(8'h41);
    queue_item(noise_item(OP_UNUSED));
    // Top of the address space with the largest budget: rows wrap around.
    send_start(24'hfffff8, 16'hffff);
    send_byte(8'hff);
    send_byte(8'h01);
    // A start drops a held first byte; a budget of one cell ends the string.
    send_byte(8'hff);
    send_start(24'h000000, 16'h0000);
    send_byte(8'h01);
    send_byte(SUBST_GLYPH);
    send_byte(SUBST_GLYPH);
    // Zero first byte gives a bare end notice.
    send_start(24'h123456, 16'd5);
    send_byte(8'h00);
    // Zero second byte draws the substitute glyph and ends the string.
    send_start(24'hffffff, 16'd3);
    send_byte(8'hff);
    send_byte(8'h00);
    // A font store in the middle of a string is seen by the next cell.
    send_start(24'($urandom()), 16'd2);
    send_byte(8'h01);
    send_load(8'h01, 3'd3, 16'ha5c3);
    send_byte(8'hff);
    send_byte(SUBST_GLYPH);
    send_byte(SUBST_GLYPH);
    send_byte(8'h01);
    send_byte(8'hff);
    settle();

    write_reg(CFG_FILL_LO, $urandom());
    write_reg(CFG_FILL_HI, $urandom());
    write_reg(CFG_STRIDE, 32'($urandom_range(0, 65535)));
    random_phase(55);
    settle();

    write_reg(CFG_FILL_LO, 32'h0000_0000);
    write_reg(CFG_FILL_HI, 32'hffff_ffff);
    write_reg(CFG_STRIDE, 32'h0000_0000);
    random_phase(55);
    settle();

    write_reg(CFG_FILL_LO, $urandom());
    write_reg(CFG_FILL_HI, $urandom());
    write_reg(CFG_STRIDE, 32'(STRIDE_RESET));
    random_phase(55);
    settle();

    // Final stretch runs without any idling on either side.
    idle_on = 1'b0;
    write_reg(CFG_FILL_LO, 32'hffff_ffff);
    write_reg(CFG_FILL_HI, 32'hffff_ffff);
    write_reg(CFG_STRIDE, 32'($urandom_range(0, 65535)));
    random_phase(45);
    settle();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
